FILE: src/psmt_pkg.sv
package psmt_pkg;

	localparam int BUFFER_DEPTH = 256;
	localparam int BUF_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_TX_ENQ   = 4'd1,
		PH_RX_LACK  = 4'd2,
		PH_TX_HDR   = 4'd3,
		PH_RX_SACK1 = 4'd4,
		PH_TX_DATA  = 4'd5,
		PH_RX_SACK2 = 4'd6,
		PH_TX_EOT   = 4'd7,
		PH_RX_BLOCK = 4'd8,
		PH_TX_ACK   = 4'd9,
		PH_RX_EOT   = 4'd10
	} phase_t;

	typedef enum logic [2:0] {
		REQ_LOAD  = 3'd0,
		REQ_READ  = 3'd1,
		REQ_WRITE = 3'd2,
		REQ_RX    = 3'd3,
		REQ_SLOT  = 3'd4,
		REQ_TICK  = 3'd5
	} req_t;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ABORT   = 3'd1;
	localparam logic [2:0] ST_PROTO   = 3'd2;
	localparam logic [2:0] ST_NAK     = 3'd3;
	localparam logic [2:0] ST_TIMEOUT = 3'd4;
	localparam logic [2:0] ST_LRC     = 3'd5;

	localparam logic [2:0] CFG_TARGET = 3'd0;
	localparam logic [2:0] CFG_RDCMD  = 3'd1;
	localparam logic [2:0] CFG_WRCMD  = 3'd2;
	localparam logic [2:0] CFG_ACKTO  = 3'd3;
	localparam logic [2:0] CFG_BLKTO  = 3'd4;

	localparam logic [7:0] C_SOH = 8'h01;
	localparam logic [7:0] C_STX = 8'h02;
	localparam logic [7:0] C_ETX = 8'h03;
	localparam logic [7:0] C_EOT = 8'h04;
	localparam logic [7:0] C_ENQ = 8'h05;
	localparam logic [7:0] C_ACK = 8'h06;
	localparam logic [7:0] C_NAK = 8'h15;
	localparam logic [7:0] C_ETB = 8'h17;
	localparam logic [7:0] C_N   = 8'h4E;
	localparam logic [7:0] C_SP  = 8'h20;
	localparam logic [7:0] C_ONE = 8'h31;
	localparam logic [7:0] C_ZERO = 8'h30;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] start_addr;
		logic [7:0]  xfer_length;
		logic [7:0]  byte_index;
		logic [7:0]  byte_value;
	} req_item_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        data_valid;
		logic [7:0]  data_index;
		logic [7:0]  data_byte;
		logic        done_res;
		logic [2:0]  status;
		logic        busy_res;
	} res_item_t;

	typedef struct packed {
		logic [7:0]  target_address;
		logic [7:0]  read_command_code;
		logic [7:0]  write_command_code;
		logic [15:0] ack_timeout_ticks;
		logic [15:0] block_timeout_ticks;
	} cfg_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
	endfunction

endpackage

FILE: src/psmt_if.sv
interface psmt_req_if;
	import psmt_pkg::*;
	logic      valid;
	logic      ready;
	req_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface psmt_res_if;
	import psmt_pkg::*;
	logic      valid;
	logic      ready;
	res_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/plc_serial_master_transaction.sv
// channel | dir | payload
// req     | in  | req_type, start_addr, xfer_length, byte_index, byte_value
// res     | out | tx_valid, tx_byte, data_valid, data_index, data_byte,
//         |     | done_res, status, busy_res
// cfg     | in  | cfg_we, cfg_index, cfg_wdata
// One result per request transaction. A request is registered in stage 1;
// the protocol FSM and LRC update run in stage 2 and fill the result
// register, so one request is taken per cycle while res can accept.
// The write buffer is a synchronous RAM read in stage 1 at the address of
// the next data byte; the FSM uses that word in stage 2.
// arst_n clears FSM state and resets config to its defaults; buffer contents are not cleared.
// A stall on res holds both stages; req.ready drops only then.
module plc_serial_master_transaction
	import psmt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	psmt_req_if.sink    req,
	psmt_res_if.source  res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	cfg_t cfg_q;
	phase_t phase_q;
	logic [15:0] saved_addr_q;
	logic [7:0]  saved_length_q;
	logic        is_write_q;
	logic [8:0]  pos_q;
	logic [7:0]  lrc_q;
	logic [15:0] tmo_q;
	logic [2:0]  fstat_q;
	logic [7:0]  held_q;

	logic        v_s1;
	req_item_t   item_s1;
	logic        rd_ok_s1;
	logic [7:0]  rdata;
	logic        adv;

	// stage 2 consumes item_s1 when the result slot is free or being taken
	assign adv = !res.valid || res.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{8'd1, 8'd48, 8'd56, 16'd500, 16'd20000};
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TARGET: cfg_q.target_address      <= cfg_wdata[7:0];
				CFG_RDCMD:  cfg_q.read_command_code   <= cfg_wdata[7:0];
				CFG_WRCMD:  cfg_q.write_command_code  <= cfg_wdata[7:0];
				CFG_ACKTO:  cfg_q.ack_timeout_ticks   <= cfg_wdata;
				CFG_BLKTO:  cfg_q.block_timeout_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// --- next data byte address, from state after stage 2 ---
	// Read address depends on pos/length after the in-flight item, so it is
	// computed from next-state values.
	phase_t      ph_n;
	logic [8:0]  pos_n;
	logic [7:0]  len_n;
	logic [8:0]  dp, sw;
	logic [7:0]  len_c;

	always_comb begin
		len_c = (v_s1 && adv) ? len_n : saved_length_q;
		dp = ((v_s1 && adv) ? pos_n : pos_q) - 9'd1;
		sw = dp ^ 9'd1;
		if (sw >= {1'b0, len_c}) sw = dp;
	end

	logic s1_load;
	assign s1_load = req.valid && adv;
	logic we_b;
	assign we_b = s1_load && req.data.req_type == REQ_LOAD
		&& {1'b0, req.data.byte_index} < 9'(BUFFER_DEPTH);

	psmt_buf u_buf (
		.clk(clk), .we(we_b),
		.waddr(req.data.byte_index[BUF_AW-1:0]),
		.wdata(req.data.byte_value),
		.re(adv), .raddr(sw[BUF_AW-1:0]), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= req.data;
			rd_ok_s1 <= sw < 9'(BUFFER_DEPTH);
		end
	end
	// A load in stage 1 to the address being read: forward it.
	logic [7:0] buf_word;
	logic fwd_s1;
	logic [7:0] fwd_val_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_s1 <= we_b && req.data.byte_index[BUF_AW-1:0] == sw[BUF_AW-1:0];
			fwd_val_s1 <= req.data.byte_value;
		end
	end
	assign buf_word = !rd_ok_s1 ? 8'd0 : (fwd_s1 ? fwd_val_s1 : rdata);

	// --- stage 2: protocol FSM ---
	logic [15:0] addr_n;
	logic        wr_n;
	logic [7:0]  lrc_n, held_n;
	logic [15:0] tmo_n;
	logic [2:0]  fstat_n;
	res_item_t   r;
	logic [15:0] a1;
	logic [7:0]  echo, hb, v;
	logic [8:0]  p, n9, bsw;

	// shared decode: header byte, station echo, swapped block position
	always_comb begin
		a1 = saved_addr_q + 16'd1;
		echo = C_SP + cfg_q.target_address;
		v = item_s1.byte_value;
		p = pos_q; n9 = {1'b0, saved_length_q};
		bsw = (p - 9'd1) ^ 9'd1;
		if (bsw >= n9) bsw = p - 9'd1;
		case (p[4:0])
			5'd0:  hb = C_SOH;
			5'd1:  hb = hex_digit(cfg_q.target_address[7:4]);
			5'd2:  hb = hex_digit(cfg_q.target_address[3:0]);
			5'd3:  hb = is_write_q ? cfg_q.write_command_code
				: cfg_q.read_command_code;
			5'd4:  hb = C_ONE;
			5'd5:  hb = hex_digit(a1[15:12]);
			5'd6:  hb = hex_digit(a1[11:8]);
			5'd7:  hb = hex_digit(a1[7:4]);
			5'd8:  hb = hex_digit(a1[3:0]);
			5'd11: hb = hex_digit(saved_length_q[7:4]);
			5'd12: hb = hex_digit(saved_length_q[3:0]);
			5'd15: hb = C_ETB;
			5'd16: hb = lrc_q;
			default: hb = C_ZERO;
		endcase
	end

	// next state
	always_comb begin
		ph_n = phase_q; pos_n = pos_q; len_n = saved_length_q;
		addr_n = saved_addr_q; wr_n = is_write_q; lrc_n = lrc_q;
		held_n = held_q; tmo_n = tmo_q; fstat_n = fstat_q;
		case (item_s1.req_type)
			REQ_READ, REQ_WRITE: begin
				if (phase_q == PH_IDLE) begin
					addr_n = item_s1.start_addr; len_n = item_s1.xfer_length;
					wr_n = item_s1.req_type == REQ_WRITE;
					ph_n = PH_TX_ENQ; pos_n = '0; lrc_n = '0; tmo_n = '0;
					fstat_n = ST_OK; held_n = '0;
				end
			end
			REQ_RX: begin
				unique case (phase_q)
					PH_RX_LACK: begin
						if (p == 9'd0) begin
							if (v == C_EOT) begin fstat_n = ST_ABORT; ph_n = PH_TX_EOT; end
							else if (v != C_N) begin fstat_n = ST_PROTO; ph_n = PH_TX_EOT; end
							else pos_n = 9'd1;
						end else if (p == 9'd1) begin
							held_n = v; pos_n = 9'd2;
						end else if (held_q == echo && v == C_NAK) begin
							fstat_n = ST_NAK; ph_n = PH_TX_EOT;
						end else if (held_q == echo && v == C_ACK) begin
							ph_n = PH_TX_HDR; pos_n = '0; lrc_n = '0;
						end else begin
							fstat_n = ST_PROTO; ph_n = PH_TX_EOT;
						end
					end
					PH_RX_SACK1, PH_RX_SACK2: begin
						if (v == C_EOT) begin fstat_n = ST_ABORT; ph_n = PH_TX_EOT; end
						else if (v == C_NAK) begin fstat_n = ST_NAK; ph_n = PH_TX_EOT; end
						else if (v != C_ACK) begin fstat_n = ST_PROTO; ph_n = PH_TX_EOT; end
						else if (phase_q == PH_RX_SACK2) begin
							ph_n = PH_TX_EOT; pos_n = '0; lrc_n = '0; fstat_n = ST_OK;
						end else if (is_write_q) begin
							ph_n = PH_TX_DATA; pos_n = '0; lrc_n = '0;
						end else begin
							ph_n = PH_RX_BLOCK; pos_n = '0;
							tmo_n = cfg_q.block_timeout_ticks;
						end
					end
					PH_RX_BLOCK: begin
						if (p == 9'd0) begin
							if (v == C_EOT) begin fstat_n = ST_ABORT; ph_n = PH_TX_EOT; end
							else begin lrc_n = '0; pos_n = 9'd1; end
						end else if (p <= n9) begin
							lrc_n = lrc_q ^ v; pos_n = p + 9'd1;
						end else if (p == n9 + 9'd1) begin
							pos_n = p + 9'd1;
						end else if (v != lrc_q) begin
							fstat_n = ST_LRC; ph_n = PH_TX_EOT;
						end else begin
							ph_n = PH_TX_ACK; pos_n = '0;
						end
					end
					PH_RX_EOT: begin
						fstat_n = (v != C_EOT) ? ST_PROTO : ST_OK;
						ph_n = PH_TX_EOT;
					end
					default: ;
				endcase
			end
			REQ_SLOT: begin
				unique case (phase_q)
					PH_TX_ENQ: begin
						if (p >= 9'd2) begin
							ph_n = PH_RX_LACK; pos_n = '0; tmo_n = cfg_q.ack_timeout_ticks;
						end else pos_n = p + 9'd1;
					end
					PH_TX_HDR: begin
						if (p >= 9'd1 && p <= 9'd14) lrc_n = lrc_q ^ hb;
						if (p >= 9'd16) begin
							ph_n = PH_RX_SACK1; pos_n = '0; tmo_n = cfg_q.ack_timeout_ticks;
						end else pos_n = p + 9'd1;
					end
					PH_TX_DATA: begin
						if (p != 9'd0 && p <= n9) lrc_n = lrc_q ^ buf_word;
						if (p >= n9 + 9'd2) begin
							ph_n = PH_RX_SACK2; pos_n = '0; tmo_n = cfg_q.ack_timeout_ticks;
						end else pos_n = p + 9'd1;
					end
					PH_TX_ACK: begin
						ph_n = PH_RX_EOT; pos_n = '0; tmo_n = cfg_q.ack_timeout_ticks;
					end
					PH_TX_EOT: ph_n = PH_IDLE;
					default: ;
				endcase
			end
			REQ_TICK: begin
				if (phase_q == PH_RX_LACK || phase_q == PH_RX_SACK1 ||
					phase_q == PH_RX_SACK2 || phase_q == PH_RX_BLOCK ||
					phase_q == PH_RX_EOT) begin
					if (tmo_q <= 16'd1) begin fstat_n = ST_TIMEOUT; ph_n = PH_TX_EOT; end
					else tmo_n = tmo_q - 16'd1;
				end
			end
			default: ;
		endcase
	end

	// result fields
	always_comb begin
		r = '0;
		case (item_s1.req_type)
			REQ_RX: begin
				if (phase_q == PH_RX_BLOCK && p != 9'd0 && p <= n9) begin
					r.data_valid = 1'b1; r.data_index = bsw[7:0]; r.data_byte = v;
				end
			end
			REQ_SLOT: begin
				unique case (phase_q)
					PH_TX_ENQ: begin
						r.tx_valid = 1'b1;
						r.tx_byte = (p == 9'd0) ? C_N : ((p == 9'd1) ? echo : C_ENQ);
					end
					PH_TX_HDR: begin
						r.tx_valid = 1'b1; r.tx_byte = hb;
					end
					PH_TX_DATA: begin
						r.tx_valid = 1'b1;
						if (p == 9'd0) r.tx_byte = C_STX;
						else if (p <= n9) r.tx_byte = buf_word;
						else if (p == n9 + 9'd1) r.tx_byte = C_ETX;
						else r.tx_byte = lrc_q;
					end
					PH_TX_ACK: begin
						r.tx_valid = 1'b1; r.tx_byte = C_ACK;
					end
					PH_TX_EOT: begin
						r.tx_valid = 1'b1; r.tx_byte = C_EOT;
						r.done_res = 1'b1; r.status = fstat_q;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		r.busy_res = ph_n != PH_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; saved_addr_q <= '0; saved_length_q <= '0;
			is_write_q <= 1'b0; pos_q <= '0; lrc_q <= '0; tmo_q <= '0;
			fstat_q <= ST_OK; held_q <= '0; res.valid <= 1'b0;
		end else if (adv) begin
			res.valid <= v_s1;
			if (v_s1) begin
				phase_q <= ph_n; saved_addr_q <= addr_n; saved_length_q <= len_n;
				is_write_q <= wr_n; pos_q <= pos_n; lrc_q <= lrc_n; tmo_q <= tmo_n;
				fstat_q <= fstat_n; held_q <= held_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			res.data <= r;
		end
	end
endmodule

FILE: src/psmt_buf.sv
module psmt_buf
	import psmt_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [BUF_AW-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [BUF_AW-1:0] raddr,
	output logic [7:0]        rdata
);
	logic [7:0] mem [BUFFER_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
